// ===== hw/rtl/ialus_pkg.sv =====
// Shared types, opcodes and constants for the 16-bit ALU with splay.
package ialus_pkg;

	localparam int DATA_W      = 16;
	localparam int MAX_SPLAY   = 64;
	localparam int SPLAY_CNT_W = (MAX_SPLAY > 1) ? $clog2(MAX_SPLAY) : 1;
	localparam int DIV_CNT_W   = $clog2(DATA_W);

	localparam logic [DATA_W-1:0] MAX_SPLAY_V = DATA_W'(MAX_SPLAY);

	typedef enum logic [3:0] {
		FN_ADD   = 4'd0,
		FN_SUB   = 4'd1,
		FN_MUL   = 4'd2,
		FN_DIV   = 4'd3,
		FN_MOD   = 4'd4,
		FN_INC   = 4'd5,
		FN_DEC   = 4'd6,
		FN_ABS   = 4'd7,
		FN_SPLAY = 4'd8
	} func_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_DIV_ZERO = 2'd1,
		ERR_SPLAY    = 2'd2,
		ERR_OPCODE   = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	// Status handed from the divider to the sequencer.
	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quot;
		logic [DATA_W-1:0] rem;
	} div_res_t;

endpackage

// ===== hw/rtl/ialus_div.sv =====
// Radix-2 restoring divider on unsigned magnitudes, one quotient bit per cycle.
module ialus_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ialus_pkg::DATA_W-1:0] dividend,
	input  logic [ialus_pkg::DATA_W-1:0] divisor,
	output ialus_pkg::div_res_t          res
);
	import ialus_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    quo_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    dvs_q;
	logic [DATA_W:0]      shifted;
	logic [DATA_W:0]      trial;

	// The partial remainder stays below the divisor, so one extra bit covers the shift.
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '1;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DATA_W-2:0], ~trial[DATA_W]};
			rem_q <= trial[DATA_W] ? shifted[DATA_W-1:0] : trial[DATA_W-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;
	assign res.rem  = rem_q;

endmodule

// ===== hw/rtl/int16_alu_with_splay.sv =====
// Top level: request decode, result sequencer, shared accumulator and output register.
// Add, sub, mul, inc, dec, abs and every error case: one result, through the accumulator and the output register.
// Divide and modulo: one result, taken from the divider, which forms one quotient
// bit per cycle. Splay of count n: n results at one per cycle while the output is not stalled.
// A new request is taken only once the last result of the previous one is registered.
// arst_n clears the sequencer and the output valid; no result is pending after reset.
module int16_alu_with_splay (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [3:0]                   func,
	input  logic [ialus_pkg::DATA_W-1:0] opnd_a,
	input  logic [ialus_pkg::DATA_W-1:0] opnd_b,
	input  logic [ialus_pkg::DATA_W-1:0] opnd_c,
	input  logic                         batch_end,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [ialus_pkg::DATA_W-1:0] value,
	output logic                         run_last,
	output logic                         batch_end_out,
	output logic [1:0]                   error_code
);
	import ialus_pkg::*;

	state_t                 state_q, state_d;
	logic                   req_fire;
	logic                   emit;
	logic                   div_go;
	logic [DATA_W-1:0]      dec_val;
	err_t                   dec_err;
	logic [SPLAY_CNT_W-1:0] dec_cnt;
	logic [DATA_W-1:0]      a_mag, b_mag, b_m1;
	logic [2*DATA_W-1:0]    prod;
	logic                   splay_ok;
	div_res_t               div_res;

	logic [DATA_W-1:0]      acc_q;
	logic [DATA_W-1:0]      step_q;
	logic [SPLAY_CNT_W-1:0] cnt_q;
	err_t                   err_q;
	logic                   bend_q;
	logic                   mod_q;
	logic                   negq_q;
	logic                   negr_q;

	logic                   rsp_valid_q;
	logic [DATA_W-1:0]      value_q;
	logic                   run_last_q;
	logic                   bend_out_q;
	err_t                   err_out_q;

	assign a_mag    = opnd_a[DATA_W-1] ? (~opnd_a + 1'b1) : opnd_a;
	assign b_mag    = opnd_b[DATA_W-1] ? (~opnd_b + 1'b1) : opnd_b;
	assign b_m1     = opnd_b - 1'b1;
	assign prod     = opnd_a * opnd_b;
	assign splay_ok = !opnd_b[DATA_W-1] && (opnd_b != '0) && (opnd_b <= MAX_SPLAY_V);

	always_comb begin
		dec_val = '0;
		dec_err = ERR_NONE;
		dec_cnt = '0;
		div_go  = 1'b0;
		case (func)
			FN_ADD: dec_val = opnd_a + opnd_b;
			FN_SUB: dec_val = opnd_a - opnd_b;
			FN_MUL: dec_val = prod[DATA_W-1:0];
			FN_DIV, FN_MOD: begin
				if (opnd_b == '0) begin
					dec_err = ERR_DIV_ZERO;
				end else begin
					div_go = 1'b1;
				end
			end
			FN_INC: dec_val = opnd_a + 1'b1;
			FN_DEC: dec_val = opnd_a - 1'b1;
			FN_ABS: dec_val = a_mag;
			FN_SPLAY: begin
				if (splay_ok) begin
					dec_val = opnd_a;
					dec_cnt = b_m1[SPLAY_CNT_W-1:0];
				end else begin
					dec_err = ERR_SPLAY;
				end
			end
			default: dec_err = ERR_OPCODE;
		endcase
	end

	ialus_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_fire && div_go),
		.dividend (a_mag),
		.divisor  (b_mag),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		emit      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = div_go ? ST_DIV : ST_EMIT;
				end
			end
			ST_DIV: begin
				if (div_res.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				emit = !rsp_valid_q || !rsp_stall;
				if (emit && (cnt_q == '0)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign req_fire = req_valid && !req_stall;

	// The accumulator doubles as the splay running sum and the single-result holder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req_fire) begin
			cnt_q <= dec_cnt;
		end else if (emit && (cnt_q != '0)) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			acc_q  <= dec_val;
			step_q <= opnd_c;
			err_q  <= dec_err;
			bend_q <= batch_end;
			mod_q  <= (func == FN_MOD);
			negq_q <= opnd_a[DATA_W-1] ^ opnd_b[DATA_W-1];
			negr_q <= opnd_a[DATA_W-1];
		end else if ((state_q == ST_DIV) && div_res.done) begin
			if (mod_q) begin
				acc_q <= negr_q ? (~div_res.rem + 1'b1) : div_res.rem;
			end else begin
				acc_q <= negq_q ? (~div_res.quot + 1'b1) : div_res.quot;
			end
		end else if (emit && (cnt_q != '0)) begin
			acc_q <= acc_q + step_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			value_q    <= acc_q;
			run_last_q <= (cnt_q == '0);
			bend_out_q <= (cnt_q == '0) && bend_q;
			err_out_q  <= err_q;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign value         = value_q;
	assign run_last      = run_last_q;
	assign batch_end_out = bend_out_q;
	assign error_code    = err_out_q;

endmodule

// ===== hw/rtl/ialus_chk.sv =====
// Port-level checker for the ALU with splay, bound to the top level.
module ialus_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_stall,
	input logic                         rsp_valid,
	input logic                         rsp_stall,
	input logic [ialus_pkg::DATA_W-1:0] value,
	input logic                         run_last,
	input logic                         batch_end_out,
	input logic [1:0]                   error_code
);
	import ialus_pkg::*;

	// A stalled result must hold until its transfer.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(value) && $stable(run_last)
			&& $stable(error_code) && $stable(batch_end_out))
		else $error("result changed while stalled");

	// Every error produces a single, final result of value zero.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (error_code != ERR_NONE) |-> run_last && (value == '0))
		else $error("error result is not a final zero");

	// The batch marker only rides on the final result of a request.
	a_bend_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && batch_end_out |-> run_last)
		else $error("batch end on a non-final result");

	// After a request transfer the block is busy on the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

endmodule

bind int16_alu_with_splay ialus_chk u_ialus_chk (.*);

// ===== tb/sv/tb_int16_alu_with_splay.sv =====
// Self-checking testbench for the 16-bit ALU with splay: directed edges, random traffic and backpressure.
module tb_int16_alu_with_splay;
	import ialus_pkg::*;

	localparam int CYCLE_LIMIT  = 10_000_000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 250;
	localparam int RANDOM_ITEMS = 480;

	typedef struct {
		logic [DATA_W-1:0] value;
		logic              last;
		logic              bend;
		err_t              err;
	} alu_result_t;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	logic [3:0]        func;
	logic [DATA_W-1:0] opnd_a;
	logic [DATA_W-1:0] opnd_b;
	logic [DATA_W-1:0] opnd_c;
	logic              batch_end;
	logic              rsp_valid;
	logic              rsp_stall;
	logic [DATA_W-1:0] value;
	logic              run_last;
	logic              batch_end_out;
	logic [1:0]        error_code;

	alu_result_t pending_results[$];
	int          fail_count;
	int          ops_sent;
	int          splays_sent;
	int          results_checked;
	int          cycle_count;
	bit          quiet;
	bit          hold_req;
	bit          holding;

	int16_alu_with_splay dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.func         (func),
		.opnd_a       (opnd_a),
		.opnd_b       (opnd_b),
		.opnd_c       (opnd_c),
		.batch_end    (batch_end),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.value        (value),
		.run_last     (run_last),
		.batch_end_out(batch_end_out),
		.error_code   (error_code)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Mostly short gaps, now and then a long one; none at all in quiet stretches.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	function automatic void add_result(int val, bit last, logic bend, err_t err);
		alu_result_t res;
		res.value = val[DATA_W-1:0];
		res.last  = last;
		res.bend  = last ? bend : 1'b0;
		res.err   = err;
		pending_results.push_back(res);
	endfunction

	// Expected results of one operation, pushed in the order the block emits them.
	function automatic void compute_alu_results(logic [3:0] fn, logic [DATA_W-1:0] a,
			logic [DATA_W-1:0] b, logic [DATA_W-1:0] c, logic bend);
		int sa;
		int sb;
		int sc;
		sa = $signed(a);
		sb = $signed(b);
		sc = $signed(c);
		case (fn)
			FN_ADD: add_result(sa + sb, 1'b1, bend, ERR_NONE);
			FN_SUB: add_result(sa - sb, 1'b1, bend, ERR_NONE);
			FN_MUL: add_result(sa * sb, 1'b1, bend, ERR_NONE);
			FN_DIV: begin
				if (sb == 0)
					add_result(0, 1'b1, bend, ERR_DIV_ZERO);
				else
					add_result(sa / sb, 1'b1, bend, ERR_NONE);
			end
			FN_MOD: begin
				if (sb == 0)
					add_result(0, 1'b1, bend, ERR_DIV_ZERO);
				else
					add_result(sa % sb, 1'b1, bend, ERR_NONE);
			end
			FN_INC: add_result(sa + 1, 1'b1, bend, ERR_NONE);
			FN_DEC: add_result(sa - 1, 1'b1, bend, ERR_NONE);
			FN_ABS: add_result((sa < 0) ? -sa : sa, 1'b1, bend, ERR_NONE);
			FN_SPLAY: begin
				if (sb < 1 || sb > MAX_SPLAY)
					add_result(0, 1'b1, bend, ERR_SPLAY);
				else
					for (int k = 0; k < sb; k++)
						add_result(sa + k * sc, k == sb - 1, bend, ERR_NONE);
			end
			default: add_result(0, 1'b1, bend, ERR_OPCODE);
		endcase
	endfunction

	// Called at a rising edge; returns at a rising edge after the transfer and any gap.
	task automatic send_op(logic [3:0] fn, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
			logic [DATA_W-1:0] c, logic bend);
		int gap;
		func      <= fn;
		opnd_a    <= a;
		opnd_b    <= b;
		opnd_c    <= c;
		batch_end <= bend;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		compute_alu_results(fn, a, b, c, bend);
		ops_sent++;
		if (fn == FN_SPLAY)
			splays_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [DATA_W-1:0] rand_operand();
		int r;
		r = $urandom_range(0, 99);
		case (r % 8)
			0: return (r < 12) ? 16'h8000 : 16'($urandom);
			1: return (r < 12) ? 16'h7FFF : 16'($urandom);
			2: return (r < 12) ? 16'hFFFF : 16'($urandom);
			3: return (r < 12) ? 16'h0000 : 16'($urandom);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_arith_edges();
		send_op(FN_ADD, 16'h7FFF, 16'h0001, 16'h0000, 1'b0);
		send_op(FN_SUB, 16'h8000, 16'h0001, 16'hFFFF, 1'b1);
		send_op(FN_MUL, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b0);
		send_op(FN_MUL, 16'h8000, 16'hFFFF, 16'h0000, 1'b1);
		send_op(FN_INC, 16'h7FFF, 16'hFFFF, 16'h0000, 1'b0);
		send_op(FN_DEC, 16'h8000, 16'h0000, 16'hFFFF, 1'b1);
		send_op(FN_ABS, 16'h8000, 16'h0000, 16'h0000, 1'b0);
		send_op(FN_ABS, 16'hFFFF, 16'h0000, 16'h0000, 1'b1);
	endtask

	task automatic test_div_mod();
		// The most negative value over minus one wraps for divide and is zero for modulo.
		send_op(FN_DIV, 16'h8000, 16'hFFFF, 16'h0000, 1'b0);
		send_op(FN_MOD, 16'h8000, 16'hFFFF, 16'h0000, 1'b1);
		send_op(FN_DIV, 16'hFFF9, 16'h0002, 16'h0000, 1'b0);
		send_op(FN_MOD, 16'hFFF9, 16'h0002, 16'h0000, 1'b1);
		send_op(FN_DIV, 16'h0007, 16'hFFFE, 16'h0000, 1'b0);
		send_op(FN_MOD, 16'h7FFF, 16'h8000, 16'h0000, 1'b1);
		send_op(FN_DIV, 16'h1234, 16'h0000, 16'h0000, 1'b1);
		send_op(FN_MOD, 16'h8000, 16'h0000, 16'h0000, 1'b0);
	endtask

	task automatic test_error_codes();
		send_op(4'd9, 16'h1111, 16'h2222, 16'h3333, 1'b1);
		send_op(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		send_op(FN_SPLAY, 16'h0005, 16'h0000, 16'h0001, 1'b1);
		send_op(FN_SPLAY, 16'h0005, 16'hFFFF, 16'h0001, 1'b0);
		send_op(FN_SPLAY, 16'h0005, 16'(MAX_SPLAY + 1), 16'h0001, 1'b1);
	endtask

	task automatic test_splay_runs();
		send_op(FN_SPLAY, 16'h8000, 16'h0001, 16'h7FFF, 1'b1);
		send_op(FN_SPLAY, 16'h7FF0, MAX_SPLAY_V, 16'h7FFF, 1'b1);
		send_op(FN_SPLAY, 16'h0010, 16'h0003, 16'hFFF8, 1'b0);
	endtask

	// The receiver holds off for a long stretch while operations keep coming.
	task automatic test_backpressure();
		// Drop the request while waiting so the last operation is not taken twice.
		req_valid <= 1'b0;
		quiet      = 1'b1;
		hold_req   = 1'b1;
		while (!holding)
			@(posedge clk);
		for (int i = 0; i < 12; i++)
			send_op(4'($urandom_range(0, 8)), rand_operand(), 16'($urandom_range(0, 6)),
				rand_operand(), 1'($urandom));
		quiet = 1'b0;
	endtask

	task automatic test_random_ops(int count);
		logic [3:0]        fn;
		logic [DATA_W-1:0] b;
		int                r;
		for (int i = 0; i < count; i++) begin
			quiet = (i >= count / 2 && i < count / 2 + 60);
			r = $urandom_range(0, 99);
			if (r < 8)
				fn = 4'($urandom_range(9, 15));
			else if (r < 30)
				fn = FN_SPLAY;
			else
				fn = 4'($urandom_range(0, 7));
			b = rand_operand();
			r = $urandom_range(0, 99);
			if (fn == FN_SPLAY) begin
				if (r < 70)
					b = 16'($urandom_range(1, 8));
				else if (r < 85)
					b = 16'($urandom_range(9, MAX_SPLAY));
				else if (r < 90)
					b = 16'h0000;
				else if (r < 95)
					b = 16'($urandom_range(MAX_SPLAY + 1, 32767));
				else
					b = 16'($urandom_range(32768, 65535));
			end else if ((fn == FN_DIV || fn == FN_MOD) && r < 15) begin
				b = (r < 8) ? 16'h0000 : 16'hFFFF;
			end
			send_op(fn, rand_operand(), b, rand_operand(), 1'($urandom));
		end
		quiet = 1'b0;
	endtask

	// Receiver stall pattern, with an occasional long hold on request.
	initial begin
		int n;
		holding = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_req) begin
				hold_req   = 1'b0;
				holding    = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding = 1'b0;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					rsp_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		alu_result_t exp_res;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no operation outstanding: value %h", value);
				fail_count++;
			end else begin
				exp_res = pending_results.pop_front();
				results_checked++;
				if (value !== exp_res.value) begin
					$error("value: expected %h, actual %h", exp_res.value, value);
					fail_count++;
				end
				if (run_last !== exp_res.last) begin
					$error("run_last: expected %b, actual %b", exp_res.last, run_last);
					fail_count++;
				end
				if (batch_end_out !== exp_res.bend) begin
					$error("batch_end_out: expected %b, actual %b", exp_res.bend,
						batch_end_out);
					fail_count++;
				end
				if (error_code !== exp_res.err) begin
					$error("error_code: expected %0d, actual %0d", exp_res.err, error_code);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
				pending_results.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		fail_count      = 0;
		ops_sent        = 0;
		splays_sent     = 0;
		results_checked = 0;
		cycle_count     = 0;
		quiet           = 1'b0;
		hold_req        = 1'b0;
		arst_n         <= 1'b0;
		req_valid      <= 1'b0;
		rsp_stall      <= 1'b0;
		func           <= FN_ADD;
		opnd_a         <= '0;
		opnd_b         <= '0;
		opnd_c         <= '0;
		batch_end      <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_arith_edges();
		test_div_mod();
		test_error_codes();
		test_splay_runs();
		test_backpressure();
		test_random_ops(RANDOM_ITEMS);

		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d operations, %0d of them splays, and checked %0d results.",
			ops_sent, splays_sent, results_checked);
		$display("Field mismatches or unexpected results: %0d", fail_count);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
